### hdl/apq_pkg.sv
// Shared types and constants for the aging priority queue.
// No dependencies; imported by apq_ctrl, apq_dpath and aging_priority_queue.
package apq_pkg;

    localparam int APQ_DEPTH = 16;

    localparam logic [15:0] MAX_ID_RST  = 16'hFFFF;
    localparam logic [7:0]  MAX_PRI_RST = 8'hFF;

    // operation codes
    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_RETRIEVE = 1'b1;

    // config register indexes
    localparam logic CFG_MAX_ID  = 1'b0;
    localparam logic CFG_MAX_PRI = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_apq_state;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // capture the input word
        logic exec;   // run the operation, load the result register
    } t_apq_cmd;

endpackage

### hdl/aging_priority_queue.sv
// Aging priority queue, top level. An accepted word is captured, then executed
// into the result register; execution waits while a stalled result is held.
// A word is taken only once the last has executed (capture, then one parallel
// update of the sorted cell array); a capture does not wait for a pending result.
// Reset (i_rst_n low, synchronous): queue empty, id limit 65535, priority limit
// 255, no result pending. Cell contents are not cleared.
module aging_priority_queue #(
    parameter int DEPTH = apq_pkg::APQ_DEPTH,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config write port
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    // input words
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_func,
    input  logic [15:0]   i_item_id,
    input  logic [7:0]    i_item_priority,
    // result words
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [15:0]   o_out_id,
    output logic [1:0]    o_status,
    output logic [CW-1:0] o_occupancy
);
    import apq_pkg::*;

    t_apq_cmd cmd;

    // Controller: two-state sequencer (capture, execute) and output valid.
    apq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Datapath: entries are kept sorted by priority in a row of cells, head in
    // cell 0. Insert shifts back every cell with a larger priority in one parallel update;
    // retrieve shifts all cells forward and ages them in the same cycle.
    apq_dpath #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_item_id       (i_item_id),
        .i_item_priority (i_item_priority),
        .o_out_id        (o_out_id),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

    // A capture is always followed by a stalled execute cycle.
    a_capture_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after capture");

    // A new result only appears out of the execute cycle.
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without execute");

    // Occupancy never exceeds the queue depth.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupancy <= CW'(DEPTH)))
        else $error("occupancy above depth");

    // Only a successful operation may return a nonzero id.
    a_id_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_out_id == 16'd0))
        else $error("nonzero id on rejected operation");

endmodule

### hdl/apq_ctrl.sv
// Controller for the aging priority queue: input handshake, sequencing and
// output valid. Depends on apq_pkg.
module apq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output apq_pkg::t_apq_cmd o_cmd
);
    import apq_pkg::*;

    t_apq_state r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // result slot is free or being emptied this cycle
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### hdl/apq_dpath.sv
// Datapath for the aging priority queue: config registers, sorted cell array
// with parallel insert/shift/aging, and result register. Depends on apq_pkg.
module apq_dpath #(
    parameter int DEPTH = apq_pkg::APQ_DEPTH,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  apq_pkg::t_apq_cmd i_cmd,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_func,
    input  logic [15:0]       i_item_id,
    input  logic [7:0]        i_item_priority,
    output logic [15:0]       o_out_id,
    output logic [1:0]        o_status,
    output logic [CW-1:0]     o_occupancy
);
    import apq_pkg::*;

    logic [15:0]   r_max_id;
    logic [7:0]    r_max_pri;
    logic [CW-1:0] r_count, n_count;

    logic          r_op;
    logic [15:0]   r_id;
    logic [7:0]    r_pri;

    logic [15:0]   r_cell_id  [DEPTH];
    logic [7:0]    r_cell_pri [DEPTH];
    logic [15:0]   n_cell_id  [DEPTH];
    logic [7:0]    n_cell_pri [DEPTH];
    logic [DEPTH-1:0] gt;

    logic [15:0]   r_res_id, n_res_id;
    logic [1:0]    r_res_st, n_res_st;
    logic [CW-1:0] r_res_occ;

    logic bad, full, do_ins, do_ret;

    // config and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_id  <= MAX_ID_RST;
            r_max_pri <= MAX_PRI_RST;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_ID:  r_max_id  <= i_cfg_data;
                    CFG_MAX_PRI: r_max_pri <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_func;
            r_id  <= i_item_id;
            r_pri <= i_item_priority;
        end
        for (int i = 0; i < DEPTH; i++) begin
            r_cell_id[i]  <= n_cell_id[i];
            r_cell_pri[i] <= n_cell_pri[i];
        end
        if (i_cmd.exec) begin
            r_res_id  <= n_res_id;
            r_res_st  <= n_res_st;
            r_res_occ <= n_count;
        end
    end

    assign bad  = (r_id > r_max_id) || (r_pri == 8'd0) || (r_pri > r_max_pri);
    assign full = (r_count == CW'(DEPTH));

    always_comb begin
        // cells holding a larger priority than the new one move back a slot
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = (CW'(i) < r_count) && (r_cell_pri[i] > r_pri);
        end

        do_ins   = 1'b0;
        do_ret   = 1'b0;
        n_res_id = '0;
        n_res_st = ST_OK;
        n_count  = r_count;
        if (i_cmd.exec) begin
            if (r_op == OP_INSERT) begin
                if (bad)       n_res_st = ST_BAD;
                else if (full) n_res_st = ST_FULL;
                else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (r_count == '0) n_res_st = ST_EMPTY;
                else begin
                    do_ret   = 1'b1;
                    n_res_id = r_cell_id[0];
                    n_count  = r_count - CW'(1);
                end
            end
        end

        for (int i = 0; i < DEPTH; i++) begin
            n_cell_id[i]  = r_cell_id[i];
            n_cell_pri[i] = r_cell_pri[i];
        end

        if (do_ins) begin
            if (gt[0] || r_count == '0) begin
                n_cell_id[0]  = r_id;
                n_cell_pri[0] = r_pri;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (gt[i-1]) begin
                    n_cell_id[i]  = r_cell_id[i-1];
                    n_cell_pri[i] = r_cell_pri[i-1];
                end else if (gt[i] || CW'(i) == r_count) begin
                    n_cell_id[i]  = r_id;
                    n_cell_pri[i] = r_pri;
                end
            end
        end else if (do_ret) begin
            // pop head, shift up, age each entry (floor 1); order is kept
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_cell_id[i]  = r_cell_id[i+1];
                n_cell_pri[i] = (r_cell_pri[i+1] > 8'd1) ? r_cell_pri[i+1] - 8'd1
                                                         : r_cell_pri[i+1];
            end
        end
    end

    assign o_out_id    = r_res_id;
    assign o_status    = r_res_st;
    assign o_occupancy = r_res_occ;

endmodule

### tb/aging_priority_queue_tb.sv
// Self-checking testbench for aging_priority_queue: a queue-fed driver, a
// monitor with a shadow sorted queue, and phases over several limit settings.
// Depends on apq_pkg and the aging_priority_queue RTL.
module aging_priority_queue_tb;
    import apq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;   // long receiver hold-off, stalls the input
    localparam int IDLE_PCT    = 34;
    localparam int TAIL_CYCLES = 8;     // settle time after the last result

    typedef struct packed {
        logic        func;
        logic [15:0] id;
        logic [7:0]  pri;
    } op_word_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  status;
        logic [4:0]  occ;
    } result_word_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  pri;
    } slot_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_MAX_ID;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = OP_INSERT;
    logic [15:0] i_item_id = '0;
    logic [7:0]  i_item_priority = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_out_id;
    logic [1:0]  o_status;
    logic [4:0]  o_occupancy;

    // shadow of the queue contents and of the two limit registers
    slot_t        shadow_slots[$];
    logic [15:0]  lim_id = MAX_ID_RST;
    logic [7:0]   lim_pri = MAX_PRI_RST;

    op_word_t     waiting_ops[$];
    result_word_t due_results[$];

    int  ops_issued = 0;
    int  results_done = 0;
    int  errors = 0;
    int  cycles = 0;
    int  settings_used = 1;
    int  peak_fill = 0;
    int  status_seen[4] = '{0, 0, 0, 0};

    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    bit  hold_start = 1'b0;
    int  hold_left = 0;

    aging_priority_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_item_id       (i_item_id),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_id        (o_out_id),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One queue operation on the shadow: returns the result word it produces.
    function automatic result_word_t queue_step(op_word_t op);
        result_word_t r;
        slot_t        s;
        int           pos;
        r = '0;
        r.status = ST_OK;
        if (op.func == OP_INSERT) begin
            if (op.id > lim_id || op.pri == 8'd0 || op.pri > lim_pri) begin
                r.status = ST_BAD;
            end else if (shadow_slots.size() >= APQ_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // goes behind every entry whose priority is not greater
                pos = shadow_slots.size();
                while (pos > 0 && shadow_slots[pos-1].pri > op.pri)
                    pos--;
                s.id  = op.id;
                s.pri = op.pri;
                shadow_slots.insert(pos, s);
            end
        end else if (shadow_slots.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            s = shadow_slots.pop_front();
            r.id = s.id;
            // aging: everything left moves one step closer to 1
            foreach (shadow_slots[i])
                if (shadow_slots[i].pri > 8'd1)
                    shadow_slots[i].pri = shadow_slots[i].pri - 8'd1;
        end
        r.occ = 5'(shadow_slots.size());
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    endtask

    // Driver: offers queued words, holds a stalled word steady.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                due_results.push_back(queue_step({i_func, i_item_id, i_item_priority}));
            if (!i_in_valid || !o_in_stall) begin
                if (waiting_ops.size() > 0 &&
                    (tx_steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    op_word_t w;
                    w = waiting_ops.pop_front();
                    ops_issued++;
                    i_func          <= w.func;
                    i_item_id       <= w.id;
                    i_item_priority <= w.pri;
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word, drives the output stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                status_seen[o_status]++;
                if (o_occupancy > peak_fill)
                    peak_fill = o_occupancy;
                if (due_results.size() == 0) begin
                    flag_mismatch("result word with nothing outstanding, status",
                                  o_status, 0);
                end else begin
                    result_word_t want;
                    want = due_results.pop_front();
                    results_done++;
                    if (o_out_id !== want.id)
                        flag_mismatch("out_id", o_out_id, want.id);
                    if (o_status !== want.status)
                        flag_mismatch("status", o_status, want.status);
                    if (o_occupancy !== want.occ)
                        flag_mismatch("occupancy", o_occupancy, want.occ);
                end
            end
            if (hold_start)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !rx_steady && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, due_results.size());
            $display("aging_priority_queue_tb: FAIL");
            $finish;
        end
    end

    // Block is idle once every issued word has had its result checked.
    task automatic wait_drained();
        @(posedge i_clk);
        while (waiting_ops.size() != 0 || ops_issued != results_done)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx == CFG_MAX_ID)
            lim_id = value;
        else
            lim_pri = value[7:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_op(logic func, logic [15:0] id, logic [7:0] pri);
        op_word_t w;
        w.func = func;
        w.id   = id;
        w.pri  = pri;
        waiting_ops.push_back(w);
    endtask

    // Random word; inserts are mostly legal, with a small share of bad arguments.
    function automatic op_word_t rand_op(int insert_pct);
        op_word_t w;
        int       roll;
        int       sel;
        w.func = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_RETRIEVE;
        w.id   = 16'($urandom());
        w.pri  = 8'($urandom());
        if (w.func == OP_INSERT) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                sel = $urandom_range(0, 2);
                if (sel == 1 && lim_pri < 8'hFF)
                    w.pri = 8'($urandom_range(int'(lim_pri) + 1, 255));
                else if (sel == 2 && lim_id < 16'hFFFF)
                    w.id = 16'($urandom_range(int'(lim_id) + 1, 65535));
                else
                    w.pri = 8'd0;
            end else begin
                w.id = 16'($urandom_range(0, int'(lim_id)));
                // narrow priorities half the time so ties and aging collide
                if (roll < 55)
                    w.pri = 8'($urandom_range(1, (lim_pri < 8'd6) ? int'(lim_pri) : 6));
                else
                    w.pri = 8'($urandom_range(1, int'(lim_pri)));
            end
        end
        return w;
    endfunction

    task automatic run_phase(logic [15:0] new_id, logic [15:0] new_pri, int count,
                             int insert_pct, bit steady, bit squeeze);
        wait_drained();
        write_reg(CFG_MAX_ID, new_id);
        write_reg(CFG_MAX_PRI, new_pri);
        settings_used++;
        tx_steady <= steady;
        rx_steady <= steady;
        for (int n = 0; n < count; n++)
            waiting_ops.push_back(rand_op(insert_pct));
        if (squeeze) begin
            @(posedge i_clk);
            hold_start <= 1'b1;
            @(posedge i_clk);
            hold_start <= 1'b0;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: empty retrieve, zero priority, extremes, a tie, aging
        push_op(OP_RETRIEVE, 16'h1234, 8'h56);
        push_op(OP_INSERT, 16'h0001, 8'd0);
        push_op(OP_INSERT, 16'hFFFF, 8'hFF);
        push_op(OP_INSERT, 16'h0000, 8'd1);
        push_op(OP_INSERT, 16'h5A5A, 8'd1);
        push_op(OP_INSERT, 16'hA5A5, 8'd3);
        repeat (5) push_op(OP_RETRIEVE, 16'hFFFF, 8'hFF);

        // tight limits; priority write carries junk in the upper byte
        wait_drained();
        write_reg(CFG_MAX_ID, 16'h00FF);
        write_reg(CFG_MAX_PRI, 16'h1F0A);
        settings_used++;
        push_op(OP_INSERT, 16'h0100, 8'd5);
        push_op(OP_INSERT, 16'h00FF, 8'd11);
        push_op(OP_INSERT, 16'h00FF, 8'd10);
        push_op(OP_INSERT, 16'h0000, 8'd0);
        push_op(OP_RETRIEVE, 16'h0000, 8'd0);

        // priority limit of zero: every insert is refused
        wait_drained();
        write_reg(CFG_MAX_PRI, 16'h0100);
        settings_used++;
        push_op(OP_INSERT, 16'h0000, 8'd1);
        push_op(OP_INSERT, 16'h0000, 8'hFF);
        push_op(OP_RETRIEVE, 16'h0000, 8'd0);

        // fill past full, a bad argument while full, then drain past empty
        wait_drained();
        write_reg(CFG_MAX_ID, MAX_ID_RST);
        write_reg(CFG_MAX_PRI, {8'h00, MAX_PRI_RST});
        settings_used++;
        for (int n = 0; n <= APQ_DEPTH; n++)
            push_op(OP_INSERT, 16'($urandom()), 8'($urandom_range(1, 255)));
        push_op(OP_INSERT, 16'h0042, 8'd0);
        for (int n = 0; n <= APQ_DEPTH; n++)
            push_op(OP_RETRIEVE, 16'($urandom()), 8'($urandom()));

        run_phase(MAX_ID_RST, 16'h00FF, 125, 55, 1'b0, 1'b0);
        run_phase(MAX_ID_RST, 16'h00FF, 125, 70, 1'b1, 1'b0);   // no idling at all
        run_phase(16'h00FF, 16'd12, 125, 70, 1'b0, 1'b0);
        run_phase(MAX_ID_RST, 16'd1, 125, 55, 1'b0, 1'b0);      // plain FIFO order
        run_phase(16'h0000, 16'h00FF, 125, 35, 1'b0, 1'b0);
        run_phase(16'h7FFF, 16'h0080, 125, 60, 1'b0, 1'b1);     // long receiver hold
        run_phase(16'($urandom()), 16'($urandom_range(1, 255)), 125, 60, 1'b0, 1'b0);
        run_phase(MAX_ID_RST, 16'h00FF, 125, 50, 1'b0, 1'b0);
        run_phase(16'($urandom()), 16'($urandom_range(1, 255)), 125, 45, 1'b0, 1'b0);
        run_phase(MAX_ID_RST, 16'h00FF, 125, 55, 1'b0, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        foreach (due_results[i])
            flag_mismatch("missing result word, status", 0, due_results[i].status);

        $display("covered %0d words over %0d limit settings, peak occupancy %0d",
                 ops_issued, settings_used, peak_fill);
        $display("statuses seen: ok %0d, full %0d, empty %0d, bad argument %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_BAD]);
        if (errors == 0 && due_results.size() == 0) begin
            $display("aging_priority_queue_tb: PASS");
        end else begin
            $display("aging_priority_queue_tb: FAIL");
        end
        $finish;
    end

endmodule

### aging_priority_queue.f
hdl/apq_pkg.sv
hdl/apq_ctrl.sv
hdl/apq_dpath.sv
hdl/aging_priority_queue.sv
tb/aging_priority_queue_tb.sv
